>>> hdl/sha1_pkg.sv
// Shared types, constants and helper functions of the SHA-1 engine.
// Depends on nothing; sha1_wmem, sha1_core and the top level import it.
package sha1_pkg;

	localparam int WORD_W    = 32;
	localparam int NUM_WORDS = 5;
	localparam int IDX_W     = 3;
	localparam int RND_W     = 7;
	localparam int LEN_W     = 61;
	localparam int FILL_W    = 6;
	localparam int MEM_AW    = 4;

	typedef logic [WORD_W-1:0] word_t;

	localparam word_t INIT_H0 = 32'h67452301;
	localparam word_t INIT_H1 = 32'hefcdab89;
	localparam word_t INIT_H2 = 32'h98badcfe;
	localparam word_t INIT_H3 = 32'h10325476;
	localparam word_t INIT_H4 = 32'hc3d2e1f0;

	localparam word_t K_0 = 32'h5a827999;
	localparam word_t K_1 = 32'h6ed9eba1;
	localparam word_t K_2 = 32'h8f1bbcdc;
	localparam word_t K_3 = 32'hca62c1d6;

	localparam logic [7:0] PAD_MARK = 8'h80;

	localparam logic [RND_W-1:0] LAST_RND  = 7'd79;
	localparam logic [RND_W-1:0] LOAD_RNDS = 7'd16;
	localparam logic [IDX_W-1:0] LAST_IDX  = 3'd4;

	typedef struct packed {
		logic load;
		logic step;
		logic fold;
		logic restart;
	} core_ctl_t;

	function automatic word_t init_word(input logic [IDX_W-1:0] i);
		word_t v;
		case (i)
			3'd0: v = INIT_H0;
			3'd1: v = INIT_H1;
			3'd2: v = INIT_H2;
			3'd3: v = INIT_H3;
			default: v = INIT_H4;
		endcase
		return v;
	endfunction

endpackage

>>> hdl/sha1_if.sv
// Handshake interfaces of the SHA-1 engine: byte input and digest output.
// Depends on nothing.
interface sha1_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       message_end;

	modport source(output valid, data_byte, byte_valid, message_end, input ready);
	modport sink(input valid, data_byte, byte_valid, message_end, output ready);
endinterface

interface sha1_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        final_word;

	modport source(output valid, digest_word, word_index, final_word, input ready);
	modport sink(input valid, digest_word, word_index, final_word, output ready);
endinterface

>>> hdl/sha1_wmem.sv
// Sixteen-word message memory: block words, then the schedule ring.
// One write port, two read ports with registered read data. Uses sha1_pkg.
module sha1_wmem
	import sha1_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [MEM_AW-1:0] waddr,
	input  word_t             wdata,
	input  logic [MEM_AW-1:0] raddr0,
	input  logic [MEM_AW-1:0] raddr1,
	output word_t             rdata0,
	output word_t             rdata1
);

	word_t mem [2**MEM_AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

>>> hdl/sha1_core.sv
// Round datapath: chaining words, working variables and the round function.
// Driven by the sequencer in the top level. Uses sha1_pkg.
module sha1_core
	import sha1_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  core_ctl_t        ctl,
	input  logic [RND_W-1:0] rnd,
	input  word_t            w,
	input  logic [IDX_W-1:0] sel,
	output word_t            word
);

	word_t chain_q [NUM_WORDS];
	word_t wv_q    [NUM_WORDS];
	word_t f, k, t;

	always_comb begin
		if (rnd < 7'd20) begin
			f = (wv_q[1] & wv_q[2]) | (~wv_q[1] & wv_q[3]);
			k = K_0;
		end else if (rnd < 7'd40) begin
			f = wv_q[1] ^ wv_q[2] ^ wv_q[3];
			k = K_1;
		end else if (rnd < 7'd60) begin
			f = (wv_q[1] & wv_q[2]) | (wv_q[1] & wv_q[3]) | (wv_q[2] & wv_q[3]);
			k = K_2;
		end else begin
			f = wv_q[1] ^ wv_q[2] ^ wv_q[3];
			k = K_3;
		end
		t = {wv_q[0][26:0], wv_q[0][31:27]} + f + wv_q[4] + k + w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				chain_q[i] <= init_word(IDX_W'(i));
			end
		end else if (ctl.restart) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				chain_q[i] <= init_word(IDX_W'(i));
			end
		end else if (ctl.fold) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				chain_q[i] <= chain_q[i] + wv_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				wv_q[i] <= chain_q[i];
			end
		end else if (ctl.step) begin
			wv_q[0] <= t;
			wv_q[1] <= wv_q[0];
			wv_q[2] <= {wv_q[1][1:0], wv_q[1][31:2]};
			wv_q[3] <= wv_q[2];
			wv_q[4] <= wv_q[3];
		end
	end

	assign word = (sel > LAST_IDX) ? chain_q[LAST_IDX] : chain_q[sel];

endmodule

>>> hdl/sha1_hash_engine_unit.sv
// Top level of the streaming SHA-1 engine: byte packing, padding, round
// sequencer and digest output. Uses sha1_pkg, sha1_if, sha1_wmem, sha1_core.
//
//   port   direction  item
//   din    sink       one message byte, byte flag, message end flag
//   dout   source     one digest word with its index and last-word flag
//
// Din items are taken only in the input state. A full block runs sixteen
// rounds of a read and a round state, then sixty-four with a second read
// state, as they share the memory's two read ports, and a fold of the
// chaining words. A closing item adds up to 72 padding bytes and one or two
// blocks, then five output items. Reset loads the initial hash values and
// clears counts. While a digest is waiting on dout, din takes no item.
module sha1_hash_engine_unit
	import sha1_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	sha1_in_if.sink    din,
	sha1_out_if.source dout
);

	localparam logic [2:0] S_IN   = 3'd0;
	localparam logic [2:0] S_PAD  = 3'd1;
	localparam logic [2:0] S_R0   = 3'd2;
	localparam logic [2:0] S_R1   = 3'd3;
	localparam logic [2:0] S_RC   = 3'd4;
	localparam logic [2:0] S_FOLD = 3'd5;
	localparam logic [2:0] S_EMIT = 3'd6;

	logic [2:0]        state_q;
	logic [RND_W-1:0]  rnd_q;
	logic [FILL_W-1:0] fill_q;
	logic [LEN_W-1:0]  len_q;
	logic [23:0]       pack_q;
	logic              padding_q;
	logic              mark_q;
	logic [3:0]        lcnt_q;
	logic [IDX_W-1:0]  idx_q;
	word_t             x_q;

	logic              accept;
	logic              put_en;
	logic [7:0]        put_byte;
	logic [7:0]        len_byte;
	logic [63:0]       len_bits;
	logic              len_phase;
	core_ctl_t         ctl;
	logic              mem_we;
	logic [MEM_AW-1:0] mem_waddr;
	word_t             mem_wdata;
	logic [MEM_AW-1:0] raddr0, raddr1;
	word_t             rdata0, rdata1;
	word_t             w_next;
	word_t             digest;

	assign din.ready = (state_q == S_IN);
	assign accept    = din.valid && din.ready;

	assign len_bits  = {len_q, 3'b000};
	assign len_byte  = 8'(len_bits >> {~lcnt_q[2:0], 3'b000});
	assign len_phase = (lcnt_q != 4'd0) || (fill_q == 6'd56);

	always_comb begin
		put_en   = 1'b0;
		put_byte = din.data_byte;
		if (state_q == S_IN) begin
			put_en = accept && din.byte_valid;
		end else if (state_q == S_PAD) begin
			put_en = 1'b1;
			if (!mark_q) begin
				put_byte = PAD_MARK;
			end else if (len_phase) begin
				put_byte = len_byte;
			end else begin
				put_byte = 8'h00;
			end
		end
	end

	always_comb begin
		raddr0 = rnd_q[MEM_AW-1:0];
		raddr1 = MEM_AW'(rnd_q - 7'd8);
		if (state_q == S_R0) begin
			if (rnd_q >= LOAD_RNDS) begin
				raddr0 = MEM_AW'(rnd_q - 7'd3);
			end
		end else if (state_q == S_R1) begin
			raddr0 = MEM_AW'(rnd_q - 7'd14);
			raddr1 = rnd_q[MEM_AW-1:0];
		end
	end

	always_comb begin
		word_t x;
		x = x_q ^ rdata0 ^ rdata1;
		if (rnd_q < LOAD_RNDS) begin
			w_next = rdata0;
		end else begin
			w_next = {x[30:0], x[31]};
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = fill_q[FILL_W-1:2];
		mem_wdata = {pack_q, put_byte};
		if (put_en && (fill_q[1:0] == 2'd3)) begin
			mem_we = 1'b1;
		end else if ((state_q == S_RC) && (rnd_q >= LOAD_RNDS)) begin
			mem_we    = 1'b1;
			mem_waddr = rnd_q[MEM_AW-1:0];
			mem_wdata = w_next;
		end
	end

	always_comb begin
		ctl         = '0;
		ctl.load    = put_en && (fill_q == 6'd63);
		ctl.step    = (state_q == S_RC);
		ctl.fold    = (state_q == S_FOLD);
		ctl.restart = (state_q == S_EMIT) && dout.ready && (idx_q == LAST_IDX);
	end

	sha1_wmem u_wmem (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.raddr0 (raddr0),
		.raddr1 (raddr1),
		.rdata0 (rdata0),
		.rdata1 (rdata1)
	);

	sha1_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.rnd    (rnd_q),
		.w      (w_next),
		.sel    (idx_q),
		.word   (digest)
	);

	always_ff @(posedge clk) begin
		if (put_en) begin
			pack_q <= {pack_q[15:0], put_byte};
		end
		if (state_q == S_R0) begin
			x_q <= '0;
		end else if (state_q == S_R1) begin
			x_q <= rdata0 ^ rdata1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IN;
			rnd_q     <= '0;
			fill_q    <= '0;
			len_q     <= '0;
			padding_q <= 1'b0;
			mark_q    <= 1'b0;
			lcnt_q    <= '0;
			idx_q     <= '0;
		end else begin
			if (put_en) begin
				fill_q <= fill_q + 6'd1;
			end
			case (state_q)
				S_IN: begin
					if (accept) begin
						if (din.byte_valid) begin
							len_q <= len_q + 61'd1;
						end
						if (din.message_end) begin
							padding_q <= 1'b1;
							mark_q    <= 1'b0;
							lcnt_q    <= '0;
						end
						if (ctl.load) begin
							rnd_q   <= '0;
							state_q <= S_R0;
						end else if (din.message_end) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					if (!mark_q) begin
						mark_q <= 1'b1;
					end else if (len_phase) begin
						lcnt_q <= lcnt_q + 4'd1;
					end
					if (ctl.load) begin
						rnd_q   <= '0;
						state_q <= S_R0;
					end
				end
				S_R0: begin
					state_q <= (rnd_q < LOAD_RNDS) ? S_RC : S_R1;
				end
				S_R1: begin
					state_q <= S_RC;
				end
				S_RC: begin
					rnd_q   <= rnd_q + 7'd1;
					state_q <= (rnd_q == LAST_RND) ? S_FOLD : S_R0;
				end
				S_FOLD: begin
					rnd_q <= '0;
					if (padding_q && (lcnt_q == 4'd8)) begin
						idx_q   <= '0;
						state_q <= S_EMIT;
					end else if (padding_q) begin
						state_q <= S_PAD;
					end else begin
						state_q <= S_IN;
					end
				end
				S_EMIT: begin
					if (dout.ready) begin
						if (idx_q == LAST_IDX) begin
							idx_q     <= '0;
							len_q     <= '0;
							fill_q    <= '0;
							padding_q <= 1'b0;
							state_q   <= S_IN;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= S_IN;
				end
			endcase
		end
	end

	assign dout.valid       = (state_q == S_EMIT);
	assign dout.digest_word = digest;
	assign dout.word_index  = idx_q;
	assign dout.final_word  = (idx_q == LAST_IDX);

endmodule

>>> hdl/sha1_chk.sv
// Port-level checker for the SHA-1 engine, bound to the top level.
// Depends on sha1_hash_engine_unit and the channel interfaces.
module sha1_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        final_word
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digest_word)
			&& $stable(word_index))
		else $error("Stalled digest item changed.");

	a_final_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (final_word == (word_index == 3'd4)))
		else $error("Last-word flag does not match the word index.");

	a_in_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("Input taken while a digest is pending.");

	a_word_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !final_word |=>
			out_valid && (word_index == $past(word_index) + 3'd1))
		else $error("Digest words out of order.");

	a_first_word: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> (word_index == 3'd0))
		else $error("Digest does not start with word zero.");

endmodule

bind sha1_hash_engine_unit sha1_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (din.ready),
	.out_valid   (dout.valid),
	.out_ready   (dout.ready),
	.digest_word (dout.digest_word),
	.word_index  (dout.word_index),
	.final_word  (dout.final_word)
);
